// File: design/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the WebSocket frame deframer.
// No dependencies; the parser, queue, output stage, top and bench import it.
package wsd_pkg;

   // Default width of the payload length counter (range 16 to 63)
   localparam int unsigned LENGTH_BITS_DEFAULT = 63;

   // Entries in the queue between parser and output stage (power of two)
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [3:0] OPC_CONT  = 4'h0;
   localparam logic [3:0] OPC_CLOSE = 4'h8;

   localparam logic [6:0] LEN_CODE_16  = 7'd126;
   localparam logic [6:0] LEN_CODE_64  = 7'd127;
   localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

   localparam logic [3:0] EXT_BYTES_16 = 4'd2;
   localparam logic [3:0] EXT_BYTES_64 = 4'd8;

   typedef enum logic [1:0] {
      KIND_PAYLOAD,
      KIND_EMPTY,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_RSV,
      ERR_RESERVED_OPC,
      ERR_CTRL_LONG,
      ERR_CTRL_FRAG,
      ERR_STRAY_CONT,
      ERR_NEW_MID_MSG
   } err_code_type;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_PAY,
      PH_EXT_SKIP,
      PH_KEY_SKIP,
      PH_PAY_SKIP
   } phase_type;

   // One classified transaction on its way to the output stage
   typedef struct packed {
      kind_type     kind;
      logic [7:0]   data;
      logic [7:0]   key;
      logic [3:0]   opcode;
      logic         is_control;
      logic         frame_final;
      logic         frame_last;
      logic         message_end;
      err_code_type error_code;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type item;
   } queue_out_type;

   function automatic work_type make_item(kind_type kind, logic [7:0] data,
                                          logic [7:0] key, logic [3:0] opc,
                                          logic ctl, logic fin, logic last,
                                          logic mend, err_code_type err);
      work_type w;
      w.kind        = kind;
      w.data        = data;
      w.key         = key;
      w.opcode      = opc;
      w.is_control  = ctl;
      w.frame_final = fin;
      w.frame_last  = last;
      w.message_end = mend;
      w.error_code  = err;
      return w;
   endfunction

   function automatic work_type make_error(err_code_type err);
      return make_item(KIND_ERROR, 8'h00, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, err);
   endfunction

endpackage

// File: design/wsd_req_if.sv
`timescale 1ns / 1ps
// Received byte channel: valid/ready handshake carrying one stream byte.
// No dependencies.
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/wsd_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one parser result.
// No dependencies.
interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic [3:0] opcode;
   logic       is_control;
   logic       frame_final;
   logic       frame_last;
   logic       message_end;
   logic [2:0] error_code;

   modport source (output valid, output kind, output payload_byte, output opcode,
                   output is_control, output frame_final, output frame_last,
                   output message_end, output error_code, input ready);
   modport sink   (input valid, input kind, input payload_byte, input opcode,
                   input is_control, input frame_final, input frame_last,
                   input message_end, input error_code, output ready);
endinterface

// File: design/wsd_front.sv
`timescale 1ns / 1ps
// Frame parser: header, extended length, masking key and payload sequencing.
// Depends on wsd_pkg; pushes classified transactions into wsd_queue.
module wsd_front #(
   parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              queue_ready,
   output logic              push,
   output wsd_pkg::work_type push_item
);
   import wsd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             fop_ff, fop_in;
   logic                   rsv_ff, rsv_in;
   logic                   mask_ff, mask_in;
   logic [3:0]             ext_left_ff, ext_left_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [7:0]             key_ff [4];
   logic [7:0]             key_in [4];
   logic [1:0]             mphase_ff, mphase_in;
   logic                   infrag_ff, infrag_in;
   logic [3:0]             mop_ff, mop_in;

   logic                   acc;
   logic [6:0]             len7;
   logic                   ctl;
   logic                   reserved;
   logic                   hdr_err;
   err_code_type           hdr_code;
   logic                   frag_err;
   err_code_type           frag_code;
   logic                   long_len;
   logic                   ext_done;
   logic [LENGTH_BITS-1:0] rem_shift;
   logic [LENGTH_BITS-1:0] len7_ext;
   logic                   key_done;
   logic                   pay_last;
   logic                   skip;
   logic                   mend;
   logic [3:0]             mop_mid;
   logic                   infrag_mid;
   logic [7:0]             pay_key;

   assign acc       = in_valid & queue_ready;
   assign len7      = in_byte[6:0];
   assign ctl       = fop_ff[3];
   assign reserved  = fop_ff inside {[4'd3:4'd7], [4'd11:4'd15]};
   assign long_len  = (len7 == LEN_CODE_16) || (len7 == LEN_CODE_64);
   assign ext_done  = ext_left_ff <= 4'd1;
   assign rem_shift = {rem_ff[LENGTH_BITS-9:0], in_byte};
   assign len7_ext  = {{(LENGTH_BITS-7){1'b0}}, len7};
   assign key_done  = mphase_ff == 2'd3;
   assign pay_last  = rem_ff[LENGTH_BITS-1:1] == '0;
   assign skip      = (phase_ff == PH_EXT_SKIP) || (phase_ff == PH_KEY_SKIP)
                      || (phase_ff == PH_PAY_SKIP);
   assign mend      = !ctl && fin_ff;
   assign pay_key   = mask_ff ? key_ff[mphase_ff] : 8'h00;

   // Header checks, in priority order
   always_comb begin
      hdr_err  = 1'b1;
      hdr_code = ERR_RSV;
      if (rsv_ff) begin
         hdr_code = ERR_RSV;
      end else if (reserved) begin
         hdr_code = ERR_RESERVED_OPC;
      end else if (ctl && (len7 > CTRL_MAX_LEN)) begin
         hdr_code = ERR_CTRL_LONG;
      end else if (ctl && !fin_ff) begin
         hdr_code = ERR_CTRL_FRAG;
      end else begin
         hdr_err = 1'b0;
      end
   end

   always_comb begin
      frag_err  = 1'b0;
      frag_code = ERR_STRAY_CONT;
      if (!ctl && (fop_ff == OPC_CONT) && !infrag_ff) begin
         frag_err  = 1'b1;
         frag_code = ERR_STRAY_CONT;
      end else if (!ctl && (fop_ff != OPC_CONT) && infrag_ff) begin
         frag_err  = 1'b1;
         frag_code = ERR_NEW_MID_MSG;
      end
   end

   // Message state as it stands once a good header is taken
   always_comb begin
      mop_mid    = mop_ff;
      infrag_mid = infrag_ff;
      if (!ctl && (fop_ff != OPC_CONT) && !frag_err) begin
         mop_mid    = fop_ff;
         infrag_mid = !fin_ff;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         case (phase_ff)
            PH_HDR0: begin
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               if (hdr_err) begin
                  phase_in = PH_HDR0;
               end else if (long_len) begin
                  phase_in = frag_err ? PH_EXT_SKIP : PH_EXT;
               end else if (in_byte[7]) begin
                  phase_in = frag_err ? PH_KEY_SKIP : PH_KEY;
               end else if (len7 == 7'd0) begin
                  phase_in = PH_HDR0;
               end else begin
                  phase_in = frag_err ? PH_PAY_SKIP : PH_PAY;
               end
            end
            PH_EXT, PH_EXT_SKIP: begin
               if (ext_done) begin
                  if (mask_ff) begin
                     phase_in = skip ? PH_KEY_SKIP : PH_KEY;
                  end else if (rem_shift == '0) begin
                     phase_in = PH_HDR0;
                  end else begin
                     phase_in = skip ? PH_PAY_SKIP : PH_PAY;
                  end
               end
            end
            PH_KEY, PH_KEY_SKIP: begin
               if (key_done) begin
                  if (rem_ff == '0) begin
                     phase_in = PH_HDR0;
                  end else begin
                     phase_in = skip ? PH_PAY_SKIP : PH_PAY;
                  end
               end
            end
            PH_PAY, PH_PAY_SKIP: begin
               if (pay_last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   // Frame and message registers, and the transaction pushed to the queue
   always_comb begin
      fin_in      = fin_ff;
      fop_in      = fop_ff;
      rsv_in      = rsv_ff;
      mask_in     = mask_ff;
      ext_left_in = ext_left_ff;
      rem_in      = rem_ff;
      key_in      = key_ff;
      mphase_in   = mphase_ff;
      infrag_in   = infrag_ff;
      mop_in      = mop_ff;
      push        = 1'b0;
      push_item   = make_error(ERR_RSV);
      if (acc) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in = in_byte[7];
               rsv_in = |in_byte[6:4];
               fop_in = in_byte[3:0];
            end
            PH_HDR1: begin
               mask_in   = in_byte[7];
               mphase_in = 2'd0;
               rem_in    = long_len ? '0 : len7_ext;
               if (long_len) begin
                  ext_left_in = (len7 == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
               end
               if (hdr_err || frag_err) begin
                  push      = 1'b1;
                  push_item = make_error(hdr_err ? hdr_code : frag_code);
                  infrag_in = 1'b0;
                  mop_in    = OPC_CLOSE;
               end else if (!long_len && !in_byte[7] && (len7 == 7'd0)) begin
                  push      = 1'b1;
                  push_item = make_item(KIND_EMPTY, 8'h00, 8'h00, ctl ? fop_ff : mop_mid,
                                        ctl, fin_ff, 1'b1, mend, ERR_RSV);
                  infrag_in = mend ? 1'b0 : infrag_mid;
                  mop_in    = mend ? OPC_CLOSE : mop_mid;
               end else begin
                  infrag_in = infrag_mid;
                  mop_in    = mop_mid;
               end
            end
            PH_EXT, PH_EXT_SKIP: begin
               rem_in      = rem_shift;
               ext_left_in = ext_done ? 4'd0 : ext_left_ff - 4'd1;
               if (ext_done) begin
                  mphase_in = 2'd0;
                  if (!mask_ff && (rem_shift == '0) && !skip) begin
                     push      = 1'b1;
                     push_item = make_item(KIND_EMPTY, 8'h00, 8'h00,
                                           ctl ? fop_ff : mop_ff, ctl, fin_ff, 1'b1,
                                           mend, ERR_RSV);
                     if (mend) begin
                        infrag_in = 1'b0;
                        mop_in    = OPC_CLOSE;
                     end
                  end
               end
            end
            PH_KEY, PH_KEY_SKIP: begin
               key_in[mphase_ff] = in_byte;
               mphase_in         = mphase_ff + 2'd1;
               if (key_done && (rem_ff == '0) && !skip) begin
                  push      = 1'b1;
                  push_item = make_item(KIND_EMPTY, 8'h00, 8'h00, ctl ? fop_ff : mop_ff,
                                        ctl, fin_ff, 1'b1, mend, ERR_RSV);
                  if (mend) begin
                     infrag_in = 1'b0;
                     mop_in    = OPC_CLOSE;
                  end
               end
            end
            PH_PAY, PH_PAY_SKIP: begin
               mphase_in = mphase_ff + 2'd1;
               rem_in    = pay_last ? '0 : rem_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               if (!skip) begin
                  push      = 1'b1;
                  push_item = make_item(KIND_PAYLOAD, in_byte, pay_key,
                                        ctl ? fop_ff : mop_ff, ctl, fin_ff, pay_last,
                                        pay_last && mend, ERR_RSV);
                  if (pay_last && mend) begin
                     infrag_in = 1'b0;
                     mop_in    = OPC_CLOSE;
                  end
               end
            end
            default: begin
               fin_in = fin_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         fin_ff      <= 1'b1;
         fop_ff      <= 4'h0;
         rsv_ff      <= 1'b0;
         mask_ff     <= 1'b0;
         ext_left_ff <= 4'd0;
         rem_ff      <= '0;
         key_ff      <= '{default: 8'h00};
         mphase_ff   <= 2'd0;
         infrag_ff   <= 1'b0;
         mop_ff      <= OPC_CLOSE;
      end else begin
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         fop_ff      <= fop_in;
         rsv_ff      <= rsv_in;
         mask_ff     <= mask_in;
         ext_left_ff <= ext_left_in;
         rem_ff      <= rem_in;
         key_ff      <= key_in;
         mphase_ff   <= mphase_in;
         infrag_ff   <= infrag_in;
         mop_ff      <= mop_in;
      end
   end

endmodule

// File: design/wsd_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified transactions between parser and output stage.
// Depends on wsd_pkg.
module wsd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wsd_pkg::work_type      push_item,
   output logic                   ready,
   input  logic                   pop,
   output wsd_pkg::queue_out_type q_out
);
   import wsd_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign ready       = count_ff != CNT_W'(QUEUE_DEPTH);
   assign q_out.valid = count_ff != '0;
   assign q_out.item  = slot_ff[rd_ptr_ff];
   assign do_pop      = pop && q_out.valid;

   // Pointers wrap on their own since the depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/wsd_back.sv
`timescale 1ns / 1ps
// Output stage: unmasks payload bytes and holds the result register.
// Depends on wsd_pkg and wsd_rsp_if; drains wsd_queue.
module wsd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  wsd_pkg::queue_out_type q_out,
   output logic                   pop,
   wsd_rsp_if.source              rsp_chan
);
   import wsd_pkg::*;

   logic         valid_ff, valid_in;
   kind_type     kind_ff;
   logic [7:0]   byte_ff, byte_in;
   logic [3:0]   opcode_ff;
   logic         ctl_ff;
   logic         final_ff;
   logic         last_ff;
   logic         mend_ff;
   err_code_type err_ff;

   assign pop     = q_out.valid && (!valid_ff || rsp_chan.ready);
   assign byte_in = (q_out.item.kind == KIND_PAYLOAD)
                    ? (q_out.item.data ^ q_out.item.key) : 8'h00;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= q_out.item.kind;
         byte_ff   <= byte_in;
         opcode_ff <= q_out.item.opcode;
         ctl_ff    <= q_out.item.is_control;
         final_ff  <= q_out.item.frame_final;
         last_ff   <= q_out.item.frame_last;
         mend_ff   <= q_out.item.message_end;
         err_ff    <= q_out.item.error_code;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.payload_byte = byte_ff;
   assign rsp_chan.opcode       = opcode_ff;
   assign rsp_chan.is_control   = ctl_ff;
   assign rsp_chan.frame_final  = final_ff;
   assign rsp_chan.frame_last   = last_ff;
   assign rsp_chan.message_end  = mend_ff;
   assign rsp_chan.error_code   = err_ff;

endmodule

// File: design/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// WebSocket (RFC 6455) receive deframer. One stream byte is taken per clock on
// req_chan and at most one result leaves per byte on rsp_chan: an unmasked payload
// byte, an "empty frame ended" marker or a protocol error. Header, extended length
// and masking key bytes give no result unless they close an empty frame or the
// header fails a check. Each result passes the queue write and then the output
// register on its way to rsp_chan. The four-entry queue between parser and
// output stage lets the input keep streaming through short stalls on rsp_chan;
// req_chan.ready only drops once that queue is full. On an error the message
// state is cleared; a fragmentation error also swallows the rest of the
// offending frame silently. LENGTH_BITS sets the width of the payload length
// counter; longer extended lengths keep their low LENGTH_BITS bits. No
// reset-time initialisation pass.
// Depends on wsd_pkg, wsd_req_if, wsd_rsp_if, wsd_front, wsd_queue and wsd_back.
module websocket_frame_deframer_top #(
   parameter int unsigned LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_chan,
   wsd_rsp_if.source rsp_chan
);
   import wsd_pkg::*;

   logic          queue_ready;
   logic          push;
   work_type      push_item;
   logic          pop;
   queue_out_type q_out;

   // A byte is taken whenever the queue has room for its possible result
   assign req_chan.ready = queue_ready;

   // Parser: walks header, length, key and payload, at most one transaction per byte
   wsd_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_byte     (req_chan.rx_byte),
      .queue_ready (queue_ready),
      .push        (push),
      .push_item   (push_item)
   );

   // Decoupling queue
   wsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .ready     (queue_ready),
      .pop       (pop),
      .q_out     (q_out)
   );

   // Output stage: unmasking and result register
   wsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_out    (q_out),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_deframer_top: drives framed byte streams
// and checks every result against a frame-parsing scoreboard held in this file.
// Depends on wsd_pkg, wsd_req_if, wsd_rsp_if and the deframer RTL.
module tb;
   import wsd_pkg::*;

   localparam int LB = LENGTH_BITS_DEFAULT;

   // Opcodes used by the stimulus beyond those in the package
   localparam logic [3:0] OPC_TEXT   = 4'h1;
   localparam logic [3:0] OPC_BINARY = 4'h2;
   localparam logic [3:0] OPC_PING   = 4'h9;
   localparam logic [3:0] OPC_PONG   = 4'hA;
   localparam logic [3:0] OPC_RSVD   = 4'hB;
   // Data and control opcodes alike are defined only for low bits 0..2
   localparam logic [2:0] OPC_LOW_MAX = 3'd2;

   // Quiet cycles (no transaction on either channel) before the run is abandoned
   localparam int unsigned STALL_LIMIT = 2000;
   // Cycles allowed after the last expected result for stray extras to show up
   localparam int unsigned TAIL_CYCLES = 16;

   typedef struct packed {
      kind_type     kind;
      logic [7:0]   payload_byte;
      logic [3:0]   opcode;
      logic         is_control;
      logic         frame_final;
      logic         frame_last;
      logic         message_end;
      err_code_type error_code;
   } deframe_result_type;

   // Frame parser mirror plus the queue of results it predicts
   class deframe_scoreboard;
      phase_type          phase        = PH_HDR0;
      logic               fin          = 1'b1;
      logic [3:0]         frame_opc    = OPC_CONT;
      logic               masked       = 1'b0;
      logic [3:0]         ext_left     = 4'd0;
      logic [LB-1:0]      remaining    = '0;
      logic [7:0]         mask_key [4] = '{default: 8'h00};
      logic [1:0]         key_idx      = 2'd0;
      logic               in_fragment  = 1'b0;
      logic [3:0]         msg_opc      = OPC_CLOSE;
      logic               rsv_seen     = 1'b0;
      deframe_result_type expected_q [$];
      int                 mismatches   = 0;
      int                 checked      = 0;
      int                 bytes_seen   = 0;
      int                 kind_seen [3] = '{default: 0};

      task report(string msg);
         mismatches++;
         $display("%0t ns  MISMATCH  %s", $time, msg);
      endtask

      function void push(kind_type k, logic [7:0] data, logic [3:0] opc, logic ctl,
                         logic f, logic last, logic mend, err_code_type err);
         deframe_result_type r;
         r.kind         = k;
         r.payload_byte = data;
         r.opcode       = opc;
         r.is_control   = ctl;
         r.frame_final  = f;
         r.frame_last   = last;
         r.message_end  = mend;
         r.error_code   = err;
         expected_q.push_back(r);
      endfunction

      function void flag_error(err_code_type code);
         in_fragment = 1'b0;
         msg_opc     = OPC_CLOSE;
         push(KIND_ERROR, 8'h00, OPC_CONT, 1'b0, 1'b0, 1'b0, 1'b0, code);
      endfunction

      // Last result of a frame; a final data frame closes its message
      function void end_frame(kind_type k, logic [7:0] data);
         logic ctl;
         logic mend;
         ctl  = frame_opc[3];
         mend = !ctl && fin;
         push(k, data, ctl ? frame_opc : msg_opc, ctl, fin, 1'b1, mend, ERR_RSV);
         if (mend) begin
            in_fragment = 1'b0;
            msg_opc     = OPC_CLOSE;
         end
         phase = PH_HDR0;
      endfunction

      function void start_body(bit skip);
         key_idx = 2'd0;
         if (remaining == '0) begin
            phase = PH_HDR0;
            if (!skip) end_frame(KIND_EMPTY, 8'h00);
         end else begin
            phase = skip ? PH_PAY_SKIP : PH_PAY;
         end
      endfunction

      function void after_length(bit skip);
         if (masked) begin
            key_idx = 2'd0;
            phase   = skip ? PH_KEY_SKIP : PH_KEY;
         end else begin
            start_body(skip);
         end
      endfunction

      // Advance the parser by one accepted stream byte
      function void note_byte(logic [7:0] b);
         bit           skip;
         bit           frag_err;
         bit           last;
         err_code_type frag_code;
         logic [6:0]   len7;
         logic [7:0]   plain;
         skip      = (phase == PH_EXT_SKIP) || (phase == PH_KEY_SKIP) || (phase == PH_PAY_SKIP);
         frag_err  = 1'b0;
         frag_code = ERR_STRAY_CONT;
         bytes_seen++;
         case (phase)
            PH_HDR0: begin
               fin       = b[7];
               rsv_seen  = |b[6:4];
               frame_opc = b[3:0];
               phase     = PH_HDR1;
            end
            PH_HDR1: begin
               len7   = b[6:0];
               masked = b[7];
               phase  = PH_HDR0;
               if (rsv_seen) begin
                  flag_error(ERR_RSV);
               end else if (frame_opc[2:0] > OPC_LOW_MAX) begin
                  flag_error(ERR_RESERVED_OPC);
               end else if (frame_opc[3] && len7 > CTRL_MAX_LEN) begin
                  flag_error(ERR_CTRL_LONG);
               end else if (frame_opc[3] && !fin) begin
                  flag_error(ERR_CTRL_FRAG);
               end else begin
                  if (!frame_opc[3]) begin
                     if (frame_opc == OPC_CONT && !in_fragment) begin
                        frag_err  = 1'b1;
                        frag_code = ERR_STRAY_CONT;
                     end else if (frame_opc != OPC_CONT && in_fragment) begin
                        frag_err  = 1'b1;
                        frag_code = ERR_NEW_MID_MSG;
                     end else if (frame_opc != OPC_CONT) begin
                        msg_opc     = frame_opc;
                        in_fragment = !fin;
                     end
                  end
                  // fragmentation faults still consume the frame, silently
                  if (frag_err) flag_error(frag_code);
                  remaining = '0;
                  if (len7 == LEN_CODE_16 || len7 == LEN_CODE_64) begin
                     ext_left = (len7 == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                     phase    = frag_err ? PH_EXT_SKIP : PH_EXT;
                  end else begin
                     remaining[6:0] = len7;
                     after_length(frag_err);
                  end
               end
            end
            PH_EXT, PH_EXT_SKIP: begin
               // big-endian; anything above the counter width falls off the top
               remaining = {remaining[LB-9:0], b};
               if (ext_left <= 4'd1) begin
                  ext_left = 4'd0;
                  after_length(skip);
               end else begin
                  ext_left = ext_left - 4'd1;
               end
            end
            PH_KEY, PH_KEY_SKIP: begin
               mask_key[key_idx] = b;
               key_idx = key_idx + 2'd1;
               if (key_idx == 2'd0) start_body(skip);
            end
            default: begin
               plain     = b ^ (masked ? mask_key[key_idx] : 8'h00);
               last      = remaining <= LB'(1);
               key_idx   = key_idx + 2'd1;
               remaining = last ? '0 : remaining - LB'(1);
               if (skip) begin
                  if (last) phase = PH_HDR0;
               end else if (last) begin
                  end_frame(KIND_PAYLOAD, plain);
               end else begin
                  push(KIND_PAYLOAD, plain, frame_opc[3] ? frame_opc : msg_opc,
                       frame_opc[3], fin, 1'b0, 1'b0, ERR_RSV);
               end
            end
         endcase
      endfunction

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("result %0d field %s: got %0h, want %0h", checked, name, got, want));
      endtask

      task check_result(deframe_result_type got);
         deframe_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected (kind %0d)", got.kind));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         kind_seen[int'(want.kind)]++;
         compare_field("kind",         8'(got.kind),         8'(want.kind));
         compare_field("payload_byte", got.payload_byte,     want.payload_byte);
         compare_field("opcode",       8'(got.opcode),       8'(want.opcode));
         compare_field("is_control",   8'(got.is_control),   8'(want.is_control));
         compare_field("frame_final",  8'(got.frame_final),  8'(want.frame_final));
         compare_field("frame_last",   8'(got.frame_last),   8'(want.frame_last));
         compare_field("message_end",  8'(got.message_end),  8'(want.message_end));
         compare_field("error_code",   8'(got.error_code),   8'(want.error_code));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   wsd_req_if req_chan ();
   wsd_rsp_if rsp_chan ();

   websocket_frame_deframer_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deframe_scoreboard board = new();

   // Percent chance per cycle that each side holds off
   int send_idle_pct = 26;
   int recv_idle_pct = 57;
   int frames_sent   = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic logic [7:0] frame_head(logic f, logic [2:0] rsv, logic [3:0] opc);
      return {f, rsv, opc};
   endfunction

   function automatic logic [3:0] pick_control_opcode();
      case ($urandom_range(2))
         0:       return OPC_CLOSE;
         1:       return OPC_PING;
         default: return OPC_PONG;
      endcase
   endfunction

   function automatic logic [3:0] pick_data_opcode();
      return $urandom_range(1) ? OPC_TEXT : OPC_BINARY;
   endfunction

   // One byte transaction on req_chan. Valid stays high on return, so the next
   // call either drops it for an idle cycle or presents the next byte - never both
   // in one time step.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      board.note_byte(b);
   endtask

   // Sends both header bytes, then lets the scoreboard's parse phase decide how
   // much follows: extended length (MSB first), key and payload until the parser
   // is back at a frame boundary. Header faults therefore stop after two bytes.
   task automatic send_frame(input logic [7:0] first, input logic masked,
                             input logic [6:0] len7, input logic [63:0] ext_len);
      logic [63:0] ext_shift;
      ext_shift = (len7 == LEN_CODE_16) ? {ext_len[15:0], 48'h0} : ext_len;
      frames_sent++;
      send_byte(first);
      send_byte({masked, len7});
      while (board.phase != PH_HDR0) begin
         if (board.phase == PH_EXT || board.phase == PH_EXT_SKIP) begin
            send_byte(ext_shift[63:56]);
            ext_shift = ext_shift << 8;
         end else begin
            send_byte(8'($urandom));
         end
      end
   endtask

   // Drop valid and hold off until every predicted result has been taken
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (board.expected_q.size() != 0);
   endtask

   // Every fault class and the message-state corners, about two dozen bytes
   task automatic run_directed();
      // empty non-final text frame opens a fragmented message
      send_frame(frame_head(1'b0, 3'b000, OPC_TEXT), 1'b0, 7'd0, 64'd0);
      // ping in the middle leaves the message open
      send_frame(frame_head(1'b1, 3'b000, OPC_PING), 1'b0, 7'd1, 64'd0);
      // new data frame while a message is open
      send_frame(frame_head(1'b1, 3'b000, OPC_BINARY), 1'b0, 7'd0, 64'd0);
      // continuation with no message open
      send_frame(frame_head(1'b1, 3'b000, OPC_CONT), 1'b0, 7'd0, 64'd0);
      // all RSV bits set
      send_frame(frame_head(1'b1, 3'b111, OPC_TEXT), 1'b0, 7'd0, 64'd0);
      // reserved control opcode
      send_frame(frame_head(1'b1, 3'b000, OPC_RSVD), 1'b0, 7'd0, 64'd0);
      // control frame asking for an extended length
      send_frame(frame_head(1'b1, 3'b000, OPC_CLOSE), 1'b0, LEN_CODE_16, 64'd0);
      // fragmented control frame
      send_frame(frame_head(1'b0, 3'b000, OPC_PONG), 1'b0, 7'd0, 64'd0);
      // masked final text frame, two bytes
      send_frame(frame_head(1'b1, 3'b000, OPC_TEXT), 1'b1, 7'd2, 64'd0);
   endtask

   // Mostly legal frames shaped by the current message state, then faulty
   // frames and frames with a wholly random first byte
   task automatic random_frame();
      int unsigned pick;
      int unsigned len_pick;
      logic        f;
      logic [2:0]  rsv;
      logic [3:0]  opc;
      logic        masked;
      logic [6:0]  len7;
      logic [63:0] ext_len;
      pick     = $urandom_range(99);
      len_pick = $urandom_range(99);
      rsv      = 3'b000;
      f        = 1'b1;
      masked   = 1'($urandom_range(1));
      ext_len  = 64'd0;
      // mostly short bodies, a few long and a few extended lengths
      if (len_pick < 70) begin
         len7 = 7'($urandom_range(12));
      end else if (len_pick < 85) begin
         len7 = 7'($urandom_range(125, 13));
      end else if (len_pick < 95) begin
         len7 = LEN_CODE_16;
         ext_len[15:0] = 16'($urandom_range(($urandom_range(4) == 0) ? 600 : 40));
      end else begin
         // 64-bit form; the top bit must be ignored
         len7 = LEN_CODE_64;
         ext_len[63]  = 1'($urandom_range(1));
         ext_len[7:0] = 8'($urandom_range(24));
      end
      if (pick < 62) begin
         if ($urandom_range(99) < 20) begin
            opc  = pick_control_opcode();
            len7 = 7'($urandom_range(20));
         end else if (board.in_fragment) begin
            opc = OPC_CONT;
            f   = $urandom_range(99) < 35;
         end else begin
            opc = pick_data_opcode();
            f   = $urandom_range(99) < 55;
         end
      end else if (pick < 90) begin
         f = 1'($urandom_range(1));
         case ($urandom_range(4))
            0: begin
               rsv = 3'($urandom_range(7, 1));
               opc = 4'($urandom);
            end
            1: opc = $urandom_range(1) ? 4'($urandom_range(7, 3)) : 4'($urandom_range(15, 11));
            2: begin
               opc  = pick_control_opcode();
               f    = 1'b1;
               len7 = $urandom_range(1) ? LEN_CODE_16 : LEN_CODE_64;
            end
            3: begin
               opc  = pick_control_opcode();
               f    = 1'b0;
               len7 = 7'($urandom_range(125));
            end
            // stray continuation or new message, whichever the state allows
            default: opc = board.in_fragment ? pick_data_opcode() : OPC_CONT;
         endcase
      end else begin
         {f, rsv, opc} = 8'($urandom);
         len7          = 7'($urandom);
      end
      send_frame(frame_head(f, rsv, opc), masked, len7, ext_len);
   endtask

   task automatic run_random(input int byte_budget);
      int stop_at;
      stop_at = board.bytes_seen + byte_budget;
      while (board.bytes_seen < stop_at) random_frame();
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain_results();

      // phase 1: sender idles 26 %, receiver 57 %
      run_random(620);
      drain_results();

      // phase 2: the other way round
      send_idle_pct = 57;
      recv_idle_pct = 26;
      run_random(620);

      // phase 3: both sides flat out
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(620);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.expected_q.size() != 0)
         board.report($sformatf("%0d expected results never arrived", board.expected_q.size()));
      $display("Sent %0d stream bytes in %0d frames; %0d results checked.",
               board.bytes_seen, frames_sent, board.checked);
      $display("Results: %0d payload bytes, %0d empty-frame ends, %0d protocol errors.",
               board.kind_seen[0], board.kind_seen[1], board.kind_seen[2]);
      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Result side: ready is redrawn every cycle; a transaction is taken on the
   // pre-edge values of valid and ready
   initial begin
      deframe_result_type got;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.kind         = kind_type'(rsp_chan.kind);
            got.payload_byte = rsp_chan.payload_byte;
            got.opcode       = rsp_chan.opcode;
            got.is_control   = rsp_chan.is_control;
            got.frame_final  = rsp_chan.frame_final;
            got.frame_last   = rsp_chan.frame_last;
            got.message_end  = rsp_chan.message_end;
            got.error_code   = err_code_type'(rsp_chan.error_code);
            board.check_result(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: gives up once neither channel has moved a transaction for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, board.expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
